FILE: rtl/bmss_pkg.sv
// Package for the bounded multi-stack set: shared constants, codes and types.
// No dependencies.
package bmss_pkg;

  localparam int unsigned NUM_STACKS_DEF   = 16;
  localparam int unsigned MAX_CAPACITY_DEF = 16;
  localparam int unsigned VALUE_WIDTH_DEF  = 32;

  localparam int OP_W     = 2;
  localparam int CAP_W    = 5;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index, taken from paddr[APB_AW-1]
  localparam logic REG_IDX_CAPACITY = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_POP_AT = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } seq_state_t;

  typedef struct packed {
    logic update;
    logic push;
  } fill_cmd_t;

endpackage

FILE: rtl/bounded_multi_stack_set.sv
// Bounded multi-stack set: push leftmost open stack, pop rightmost used or named.
// Each item executes with store access, then loads once the output register is free.
// The sequencer steps through idle, execute and load, and takes new items only in idle.
// A new item is taken while the previous result waits in the output register.
// Reset: fill counts and pointers cleared, capacity 16; store contents not cleared.
// Depends on bmss_pkg, bmss_track, bmss_store.
module bounded_multi_stack_set import bmss_pkg::*; #(
  parameter int unsigned NUM_STACKS   = NUM_STACKS_DEF,
  parameter int unsigned MAX_CAPACITY = MAX_CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_AW-1:0]             paddr,
  input  logic [APB_DW-1:0]             pwdata,
  output logic [APB_DW-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OP_W-1:0]               operation,
  input  logic signed [VALUE_WIDTH-1:0] push_value,
  input  logic [IDX_W-1:0]              stack_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] popped_value,
  output logic [STATUS_W-1:0]           status
);

  localparam int unsigned SW    = $clog2(NUM_STACKS);
  localparam int unsigned FW    = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned DEPTH = NUM_STACKS * MAX_CAPACITY;
  localparam int unsigned AW    = $clog2(DEPTH);

  seq_state_t state, state_next;

  logic [CAP_W-1:0]       stack_capacity;
  logic [FW-1:0]          cap_eff;
  logic                   cfg_we;

  op_t                    op_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [IDX_W-1:0]       idx_q;
  status_t                status_q;
  status_t                exec_status;
  logic                   rd_ok_q;

  logic [SW-1:0]          sel;
  logic                   exec_ok;
  logic [FW-1:0]          fill_sel;
  logic [FW-1:0]          slot;
  logic [AW-1:0]          addr;
  logic [SW:0]            leftmost_open;
  logic [SW-1:0]          rightmost_used;
  logic [VALUE_WIDTH-1:0] rdata;
  fill_cmd_t              cmd;
  logic                   mem_we;
  logic                   mem_re;
  logic                   exec_en;
  logic                   load_en;
  logic                   take_in;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready & (paddr[APB_AW-1] == REG_IDX_CAPACITY);
  assign prdata = (paddr[APB_AW-1] == REG_IDX_CAPACITY) ?
                  {{(APB_DW-CAP_W){1'b0}}, stack_capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      stack_capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    if (stack_capacity == '0) begin
      cap_eff = FW'(1);
    end else if (32'(stack_capacity) > MAX_CAPACITY) begin
      cap_eff = FW'(MAX_CAPACITY);
    end else begin
      cap_eff = FW'(stack_capacity);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    exec_en    = 1'b0;
    load_en    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        exec_en    = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid || out_ready) begin
          load_en    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign take_in = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (take_in) begin
      op_q    <= op_t'(operation);
      value_q <= push_value;
      idx_q   <= stack_index;
    end
  end

  // decode of the held item against the pointers
  always_comb begin
    sel         = '0;
    exec_ok     = 1'b0;
    exec_status = ST_OK;
    case (op_q)
      OP_PUSH: begin
        sel         = leftmost_open[SW-1:0];
        exec_ok     = leftmost_open != (SW+1)'(NUM_STACKS);
        exec_status = exec_ok ? ST_OK : ST_FULL;
      end
      OP_POP: begin
        sel         = rightmost_used;
        exec_ok     = fill_sel != '0;
        exec_status = exec_ok ? ST_OK : ST_EMPTY;
      end
      OP_POP_AT: begin
        sel         = SW'(idx_q);
        exec_ok     = (32'(idx_q) < NUM_STACKS) && (fill_sel != '0);
        exec_status = exec_ok ? ST_OK : ST_EMPTY;
      end
      default: begin
        sel         = '0;
        exec_ok     = 1'b0;
        exec_status = ST_OK;
      end
    endcase
  end

  assign slot       = (op_q == OP_PUSH) ? fill_sel : fill_sel - FW'(1);
  assign addr       = AW'(32'(sel) * MAX_CAPACITY + 32'(slot));
  assign cmd.update = exec_en & exec_ok;
  assign cmd.push   = op_q == OP_PUSH;
  assign mem_we     = exec_en & exec_ok & (op_q == OP_PUSH);
  assign mem_re     = exec_en & exec_ok & (op_q != OP_PUSH);

  always_ff @(posedge clk) begin
    if (exec_en) begin
      status_q <= exec_status;
      rd_ok_q  <= exec_ok & (op_q != OP_PUSH);
    end
  end

  bmss_track #(
    .NUM_STACKS   (NUM_STACKS),
    .MAX_CAPACITY (MAX_CAPACITY),
    .SW           (SW),
    .FW           (FW)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .cap_eff        (cap_eff),
    .sel            (sel),
    .cmd            (cmd),
    .fill_sel       (fill_sel),
    .leftmost_open  (leftmost_open),
    .rightmost_used (rightmost_used)
  );

  bmss_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (addr),
    .wdata (value_q),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      popped_value <= rd_ok_q ? rdata : '0;
      status       <= status_q;
    end
  end

endmodule

FILE: rtl/bmss_store.sv
// Value store for all stacks: single-port RAM with registered read data.
// Depends on nothing.
module bmss_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/bmss_track.sv
// Per-stack fill counters with the shared increment/decrement unit, and the
// registered leftmost-open / rightmost-used priority encoders. Uses bmss_pkg.
module bmss_track import bmss_pkg::*; #(
  parameter int unsigned NUM_STACKS   = NUM_STACKS_DEF,
  parameter int unsigned MAX_CAPACITY = MAX_CAPACITY_DEF,
  parameter int unsigned SW           = 4,
  parameter int unsigned FW           = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [FW-1:0] cap_eff,
  input  logic [SW-1:0] sel,
  input  fill_cmd_t     cmd,
  output logic [FW-1:0] fill_sel,
  output logic [SW:0]   leftmost_open,
  output logic [SW-1:0] rightmost_used
);

  logic [FW-1:0] stack_fill [NUM_STACKS];
  logic [FW-1:0] fill_upd;
  logic [SW:0]   leftmost_open_next;
  logic [SW-1:0] rightmost_used_next;

  assign fill_sel = stack_fill[sel];
  assign fill_upd = cmd.push ? fill_sel + FW'(1) : fill_sel - FW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_fill[i] <= '0;
      end
    end else if (cmd.update) begin
      stack_fill[sel] <= fill_upd;
    end
  end

  always_comb begin
    leftmost_open_next  = (SW+1)'(NUM_STACKS);
    rightmost_used_next = '0;
    for (int i = NUM_STACKS - 1; i >= 0; i--) begin
      if (stack_fill[i] < cap_eff) begin
        leftmost_open_next = (SW+1)'(i);
      end
    end
    for (int i = 0; i < NUM_STACKS; i++) begin
      if (stack_fill[i] != '0) begin
        rightmost_used_next = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftmost_open  <= '0;
      rightmost_used <= '0;
    end else begin
      leftmost_open  <= leftmost_open_next;
      rightmost_used <= rightmost_used_next;
    end
  end

endmodule

FILE: rtl/bmss_checker.sv
// Port-level checks for bounded_multi_stack_set, bound to the top level.
// Uses bmss_pkg.
module bmss_checker import bmss_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [VALUE_WIDTH-1:0] popped_value,
  input logic [STATUS_W-1:0]           status
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> popped_value == '0)
    else $error("failed operation returned a value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(popped_value) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind bounded_multi_stack_set bmss_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_bmss_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .popped_value (popped_value),
  .status       (status)
);
